// ----- src/tcsp_pkg.sv -----
// ----------------------------------------------------------------------------
// Telnet command stream parser package
// Shared codes, result kinds and the request and result structures.
// ----------------------------------------------------------------------------
package tcsp_pkg;

    localparam int MAX_OPTION_DEFAULT = 49;

    localparam int BYTE_W = 8;
    localparam int OPT_W  = 6;
    localparam int KIND_W = 3;

    localparam logic [7:0] CODE_SE   = 8'd240;
    localparam logic [7:0] CMD_MIN   = 8'd240;
    localparam logic [7:0] CODE_SB   = 8'd250;
    localparam logic [7:0] CODE_WILL = 8'd251;
    localparam logic [7:0] CODE_IAC  = 8'hFF;

    localparam logic [1:0] VERB_WILL = 2'd0;
    localparam logic [1:0] VERB_WONT = 2'd1;
    localparam logic [1:0] VERB_DO   = 2'd2;
    localparam logic [1:0] VERB_DONT = 2'd3;

    localparam logic ERR_STRAY_SE = 1'b0;
    localparam logic ERR_BAD_PAIR = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_DATA    = 3'd0,
        KIND_RUN_END = 3'd1,
        KIND_COMMAND = 3'd2,
        KIND_NEGOT   = 3'd3,
        KIND_SUB_BYTE = 3'd4,
        KIND_SUB_END = 3'd5,
        KIND_ERROR   = 3'd6
    } kind_t;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_in;
        logic              end_of_buffer;
    } request_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] command_code;
        logic [OPT_W-1:0]  option_code;
        logic              message_end;
        logic              local_enabled;
        logic              remote_enabled;
        logic              error_code;
    } result_t;

endpackage

// ----- src/tcsp_in_stage.sv -----
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted request until the parser consumes it.
// ----------------------------------------------------------------------------
module tcsp_in_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  tcsp_pkg::request_t s_req,
    input  logic              advance,
    output logic              req_valid,
    output tcsp_pkg::request_t req
);

    logic               valid_reg;
    logic               valid_next;
    tcsp_pkg::request_t req_reg;

    assign s_tready  = !valid_reg || advance;
    assign req_valid = valid_reg;
    assign req       = req_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            req_reg <= s_req;
        end
    end

endmodule

// ----- src/tcsp_core.sv -----
// ----------------------------------------------------------------------------
// Parser core
// Phase machine and option enable bits; decodes one byte per advance.
// ----------------------------------------------------------------------------
module tcsp_core
#(
    parameter int MAX_OPTION = tcsp_pkg::MAX_OPTION_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  tcsp_pkg::request_t req,
    output logic               res_valid,
    output tcsp_pkg::result_t  res
);

    localparam int NOPT  = MAX_OPTION + 2;
    localparam int IDX_W = $clog2(NOPT);

    typedef enum logic [2:0] {
        PH_NORMAL,
        PH_IAC,
        PH_VERB,
        PH_SBOPT,
        PH_SUB,
        PH_SUBIAC,
        PH_DROP_NORMAL,
        PH_DROP_SUB
    } phase_t;

    phase_t                       phase_reg;
    phase_t                       phase_next;
    logic [1:0]                   verb_reg;
    logic [1:0]                   verb_next;
    logic                         run_open_reg;
    logic                         run_open_next;
    logic [tcsp_pkg::OPT_W-1:0]   sub_opt_reg;
    logic [tcsp_pkg::OPT_W-1:0]   sub_opt_next;
    logic [NOPT-1:0]              local_reg;
    logic [NOPT-1:0]              local_next;
    logic [NOPT-1:0]              remote_reg;
    logic [NOPT-1:0]              remote_next;

    logic [7:0]                   b;
    logic                         eob;
    logic [7:0]                   verb_diff;
    logic [tcsp_pkg::OPT_W-1:0]   opt_map;
    logic [IDX_W-1:0]             opt_idx;

    assign b         = req.byte_in;
    assign eob       = req.end_of_buffer;
    assign verb_diff = b - tcsp_pkg::CODE_WILL;
    assign opt_map   = (b <= 8'(MAX_OPTION)) ? b[tcsp_pkg::OPT_W-1:0]
                                             : tcsp_pkg::OPT_W'(MAX_OPTION + 1);
    assign opt_idx   = opt_map[IDX_W-1:0];

    always_comb
    begin
        phase_next    = phase_reg;
        verb_next     = verb_reg;
        run_open_next = run_open_reg;
        sub_opt_next  = sub_opt_reg;
        local_next    = local_reg;
        remote_next   = remote_reg;
        res_valid     = 1'b0;
        res           = '0;
        res.kind      = tcsp_pkg::KIND_DATA;

        unique case (phase_reg)
            PH_NORMAL:
            begin
                if (b == tcsp_pkg::CODE_IAC)
                begin
                    phase_next = PH_IAC;
                    if (run_open_reg)
                    begin
                        run_open_next = 1'b0;
                        res_valid     = 1'b1;
                        res.kind      = tcsp_pkg::KIND_RUN_END;
                    end
                end
                else
                begin
                    run_open_next   = !eob;
                    res_valid       = 1'b1;
                    res.kind        = tcsp_pkg::KIND_DATA;
                    res.data_byte   = b;
                    res.message_end = eob;
                end
            end

            PH_IAC:
            begin
                priority if (b == tcsp_pkg::CODE_IAC)
                begin
                    phase_next      = PH_NORMAL;
                    res_valid       = 1'b1;
                    res.kind        = tcsp_pkg::KIND_DATA;
                    res.data_byte   = tcsp_pkg::CODE_IAC;
                    res.message_end = 1'b1;
                end
                else if (b >= tcsp_pkg::CODE_WILL)
                begin
                    verb_next  = verb_diff[1:0];
                    phase_next = PH_VERB;
                end
                else if (b == tcsp_pkg::CODE_SB)
                begin
                    phase_next = PH_SBOPT;
                end
                else if (b == tcsp_pkg::CODE_SE)
                begin
                    phase_next     = eob ? PH_NORMAL : PH_DROP_NORMAL;
                    res_valid      = 1'b1;
                    res.kind       = tcsp_pkg::KIND_ERROR;
                    res.error_code = tcsp_pkg::ERR_STRAY_SE;
                end
                else
                begin
                    phase_next       = PH_NORMAL;
                    res_valid        = 1'b1;
                    res.kind         = tcsp_pkg::KIND_COMMAND;
                    res.command_code = (b >= tcsp_pkg::CMD_MIN) ? b : 8'd0;
                end
            end

            PH_VERB:
            begin
                unique case (verb_reg)
                    tcsp_pkg::VERB_WILL: remote_next[opt_idx] = 1'b1;
                    tcsp_pkg::VERB_WONT: remote_next[opt_idx] = 1'b0;
                    tcsp_pkg::VERB_DO:   local_next[opt_idx]  = 1'b1;
                    tcsp_pkg::VERB_DONT: local_next[opt_idx]  = 1'b0;
                    default:             local_next[opt_idx]  = 1'b0;
                endcase
                phase_next         = PH_NORMAL;
                res_valid          = 1'b1;
                res.kind           = tcsp_pkg::KIND_NEGOT;
                res.command_code   = tcsp_pkg::CODE_WILL + {6'd0, verb_reg};
                res.option_code    = opt_map;
                res.local_enabled  = local_next[opt_idx];
                res.remote_enabled = remote_next[opt_idx];
            end

            PH_SBOPT:
            begin
                sub_opt_next = opt_map;
                phase_next   = PH_SUB;
            end

            PH_SUB:
            begin
                if (b == tcsp_pkg::CODE_IAC)
                begin
                    phase_next = PH_SUBIAC;
                end
                else
                begin
                    res_valid       = 1'b1;
                    res.kind        = tcsp_pkg::KIND_SUB_BYTE;
                    res.data_byte   = b;
                    res.option_code = sub_opt_reg;
                end
            end

            PH_SUBIAC:
            begin
                priority if (b == tcsp_pkg::CODE_SE)
                begin
                    phase_next      = PH_NORMAL;
                    res_valid       = 1'b1;
                    res.kind        = tcsp_pkg::KIND_SUB_END;
                    res.option_code = sub_opt_reg;
                end
                else if (b == tcsp_pkg::CODE_IAC)
                begin
                    phase_next      = PH_SUB;
                    res_valid       = 1'b1;
                    res.kind        = tcsp_pkg::KIND_SUB_BYTE;
                    res.data_byte   = tcsp_pkg::CODE_IAC;
                    res.option_code = sub_opt_reg;
                end
                else
                begin
                    // subnegotiation stays open after a bad pair
                    phase_next     = eob ? PH_SUB : PH_DROP_SUB;
                    res_valid      = 1'b1;
                    res.kind       = tcsp_pkg::KIND_ERROR;
                    res.error_code = tcsp_pkg::ERR_BAD_PAIR;
                end
            end

            PH_DROP_NORMAL:
            begin
                if (eob)
                begin
                    phase_next = PH_NORMAL;
                end
            end

            PH_DROP_SUB:
            begin
                if (eob)
                begin
                    phase_next = PH_SUB;
                end
            end

            default:
            begin
                phase_next = PH_NORMAL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_NORMAL;
            verb_reg     <= 2'd0;
            run_open_reg <= 1'b0;
            sub_opt_reg  <= '0;
            local_reg    <= '0;
            remote_reg   <= '0;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            verb_reg     <= verb_next;
            run_open_reg <= run_open_next;
            sub_opt_reg  <= sub_opt_next;
            local_reg    <= local_next;
            remote_reg   <= remote_next;
        end
    end

`ifndef SYNTHESIS
    a_drop_silent: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (phase_reg == PH_DROP_NORMAL || phase_reg == PH_DROP_SUB)
        |-> !res_valid)
        else $error("result produced while dropping the rest of a buffer");

    a_data_run_state: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_valid && res.kind == tcsp_pkg::KIND_DATA
        |=> run_open_reg == !$past(res.message_end))
        else $error("data run flag disagrees with the last data byte");

    a_sub_close: assert property (@(posedge clk) disable iff (!rst_n)
        advance && phase_reg == PH_SUBIAC && b == tcsp_pkg::CODE_SE
        |=> phase_reg == PH_NORMAL)
        else $error("IAC SE did not close the subnegotiation");

    a_option_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.option_code <= tcsp_pkg::OPT_W'(MAX_OPTION + 1))
        else $error("option code beyond the unknown slot");
`endif

endmodule

// ----- src/tcsp_out_stage.sv -----
// ----------------------------------------------------------------------------
// Output register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module tcsp_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  tcsp_pkg::result_t res,
    input  logic              m_tready,
    output logic              m_tvalid,
    output tcsp_pkg::result_t m_res
);

    logic              valid_reg;
    logic              valid_next;
    tcsp_pkg::result_t res_reg;

    assign m_tvalid = valid_reg;
    assign m_res    = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule

// ----- src/telnet_command_stream_parser.sv -----
// An accepted byte is held in the input register; its result goes to the output register
// when the core advances. Throughput: one byte per cycle unless the master side stalls.
// A byte that gives no result is still consumed, but only when the output stage has room.
// Reset (asynchronous, active low) returns to the normal data phase, closes any data
// run and clears every local and remote option enable bit.
// ----------------------------------------------------------------------------
// Telnet command stream parser
// IAC sequence decoder with option state, one byte per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module telnet_command_stream_parser
#(
    parameter int MAX_OPTION = tcsp_pkg::MAX_OPTION_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    input  logic        s_tlast,   // end_of_buffer
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] data_byte, [15:8] command_code, [21:16] option_code,
    // [22] local_enabled, [23] remote_enabled, [24] error_code, [31:25] zero
    output logic [31:0] m_tdata,
    output logic [2:0]  m_tuser,   // [2:0] kind
    output logic        m_tlast    // message_end
);

    tcsp_pkg::request_t s_req;
    tcsp_pkg::request_t req;
    tcsp_pkg::result_t  res;
    tcsp_pkg::result_t  m_res;
    logic               req_valid;
    logic               res_valid;
    logic               advance;

    assign s_req.byte_in       = s_tdata;
    assign s_req.end_of_buffer = s_tlast;

    // consume the held request whenever the output register can take a result
    assign advance = req_valid && (!m_tvalid || m_tready);

    tcsp_in_stage u_in_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_req     (s_req),
        .advance   (advance),
        .req_valid (req_valid),
        .req       (req)
    );

    tcsp_core #(
        .MAX_OPTION (MAX_OPTION)
    ) u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .req       (req),
        .res_valid (res_valid),
        .res       (res)
    );

    tcsp_out_stage u_out_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance && res_valid),
        .res      (res),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_res    (m_res)
    );

    assign m_tdata = {7'd0, m_res.error_code, m_res.remote_enabled, m_res.local_enabled,
                      m_res.option_code, m_res.command_code, m_res.data_byte};
    assign m_tuser = m_res.kind;
    assign m_tlast = m_res.message_end;

endmodule
